// ===== design/wnm_pkg.sv =====
// Shared types, codes and helpers for the wildcard name matcher.
package wnm_pkg;

   localparam int FUNC_W      = 2;
   localparam int CH_W        = 8;
   localparam int PAT_MAX_DEF = 32;

   localparam logic [CH_W-1:0] STAR_CHAR  = 8'h2A;
   localparam logic [CH_W-1:0] QMARK_CHAR = 8'h3F;
   localparam logic [CH_W-1:0] LOWER_A    = 8'h61;
   localparam logic [CH_W-1:0] LOWER_Z    = 8'h7A;
   localparam logic [CH_W-1:0] CASE_DIFF  = 8'h20;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PAT_BYTE  = 2'd0,
      FUNC_PAT_END   = 2'd1,
      FUNC_NAME_BYTE = 2'd2,
      FUNC_NAME_END  = 2'd3
   } func_type;

   typedef struct packed {
      func_type        func;
      logic [CH_W-1:0] ch;
      logic            is_star;
      logic            is_qmark;
   } item_type;

   function automatic logic [CH_W-1:0] fold_case(input logic [CH_W-1:0] c);
      if (c >= LOWER_A && c <= LOWER_Z) begin
         return c - CASE_DIFF;
      end
      return c;
   endfunction

endpackage

// ===== design/wnm_if.sv =====
// Request and response channel interfaces of the wildcard name matcher.
interface wnm_req_if;
   import wnm_pkg::*;
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [CH_W-1:0]   ch;
   modport source (output valid, output func, output ch, input ready);
   modport sink (input valid, input func, input ch, output ready);
endinterface

interface wnm_rsp_if;
   logic valid;
   logic ready;
   logic match;
   logic error;
   modport source (output valid, output match, output error, input ready);
   modport sink (input valid, input match, input error, output ready);
endinterface

// ===== design/wnm_front.sv =====
// Front end: takes requests, classifies them and queues them for the back end.
module wnm_front (
   input  logic              clock,
   input  logic              reset,
   wnm_req_if.sink           req_chan,
   output wnm_pkg::item_type head_item,
   output logic              head_valid,
   input  logic              head_pop
);
   import wnm_pkg::*;

   item_type   entry_ff [2];
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   class_item;
   logic       push;
   logic       pop;

   always_comb begin
      class_item.func     = func_type'(req_chan.func);
      class_item.ch       = fold_case(req_chan.ch);
      class_item.is_star  = (req_chan.ch == STAR_CHAR);
      class_item.is_qmark = (req_chan.ch == QMARK_CHAR);
   end

   assign req_chan.ready = (count_ff != 2'd2);
   assign push           = req_chan.valid && req_chan.ready;
   assign head_valid     = (count_ff != 2'd0);
   assign pop            = head_pop && head_valid;
   assign head_item      = entry_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= class_item;
      end
   end

endmodule

// ===== design/wnm_back.sv =====
// Back end: pattern store, active position set and registered match response.
module wnm_back #(
   parameter int PAT_MAX = wnm_pkg::PAT_MAX_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  wnm_pkg::item_type head_item,
   input  logic              head_valid,
   output logic              head_pop,
   wnm_rsp_if.source         rsp_chan
);
   import wnm_pkg::*;

   localparam int LEN_W = $clog2(PAT_MAX + 1);
   localparam int LVL   = $clog2(PAT_MAX + 1);

   logic [CH_W-1:0]    store_ff [PAT_MAX];
   logic [CH_W-1:0]    store_in [PAT_MAX];
   logic [PAT_MAX-1:0] star_ff, star_in;
   logic [PAT_MAX-1:0] qmark_ff, qmark_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic               ovf_ff, ovf_in;
   logic               loading_ff, loading_in;
   logic [PAT_MAX:0]   active_ff, active_in;
   logic [PAT_MAX:0]   start_ff, start_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_match_ff, rsp_match_in;
   logic               rsp_error_ff, rsp_error_in;

   logic               out_free;
   logic               take;
   logic [PAT_MAX:0]   cur;
   logic [PAT_MAX:0]   start_base;
   logic [LEN_W-1:0]   base_len;
   logic [PAT_MAX:0]   gen;
   logic [PAT_MAX:0]   prop;
   logic               live;
   logic               hit;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign head_pop = head_valid && (head_item.func != FUNC_NAME_END || out_free);
   assign take     = head_pop;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.match = rsp_match_ff;
   assign rsp_chan.error = rsp_error_ff;

   assign cur        = loading_ff ? start_ff : active_ff;
   assign start_base = loading_ff ? start_ff : (PAT_MAX + 1)'(1);
   assign base_len   = loading_ff ? len_ff : '0;

   // advance every position by one name byte, then close star runs
   always_comb begin
      gen  = '0;
      prop = '0;
      live = 1'b0;
      hit  = 1'b0;
      for (int i = 0; i < PAT_MAX; i++) begin
         live = cur[i] && (LEN_W'(i) < len_ff);
         hit  = qmark_ff[i] || (store_ff[i] == head_item.ch);
         if (live && star_ff[i]) begin
            gen[i] = 1'b1;
         end
         if (live && !star_ff[i] && hit) begin
            gen[i+1] = 1'b1;
         end
         prop[i+1] = star_ff[i] && (LEN_W'(i) < len_ff);
      end
      for (int l = 0; l < LVL; l++) begin
         gen  = gen | (prop & (gen << (1 << l)));
         prop = prop & (prop << (1 << l));
      end
   end

   always_comb begin
      store_in     = store_ff;
      star_in      = star_ff;
      qmark_in     = qmark_ff;
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      loading_in   = loading_ff;
      active_in    = active_ff;
      start_in     = start_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_match_in = rsp_match_ff;
      rsp_error_in = rsp_error_ff;
      if (take) begin
         unique case (head_item.func)
            FUNC_PAT_BYTE: begin
               loading_in = 1'b1;
               start_in   = start_base;
               ovf_in     = loading_ff ? ovf_ff : 1'b0;
               len_in     = base_len;
               if (base_len < LEN_W'(PAT_MAX)) begin
                  len_in = base_len + LEN_W'(1);
                  for (int i = 0; i < PAT_MAX; i++) begin
                     if (base_len == LEN_W'(i)) begin
                        store_in[i]   = head_item.ch;
                        star_in[i]    = head_item.is_star;
                        qmark_in[i]   = head_item.is_qmark;
                        start_in[i+1] = start_base[i] && head_item.is_star;
                     end
                  end
               end else begin
                  ovf_in = 1'b1;
               end
            end
            FUNC_PAT_END: begin
               loading_in = 1'b0;
               active_in  = start_ff;
            end
            FUNC_NAME_BYTE: begin
               loading_in = 1'b0;
               active_in  = gen;
            end
            FUNC_NAME_END: begin
               loading_in   = 1'b0;
               active_in    = start_ff;
               rsp_valid_in = 1'b1;
               rsp_match_in = cur[len_ff];
               rsp_error_in = ovf_ff;
            end
            default: begin
               loading_in = loading_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         loading_ff   <= 1'b1;
         active_ff    <= (PAT_MAX + 1)'(1);
         start_ff     <= (PAT_MAX + 1)'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         loading_ff   <= loading_in;
         active_ff    <= active_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      store_ff     <= store_in;
      star_ff      <= star_in;
      qmark_ff     <= qmark_in;
      rsp_match_ff <= rsp_match_in;
      rsp_error_ff <= rsp_error_in;
   end

endmodule

// ===== design/wildcard_name_matcher.sv =====
// Wildcard name matcher: case-insensitive glob match of streamed names.
// Load a pattern byte by byte (func 0), end it (func 1), then stream name
// bytes (func 2) and close each name (func 3) to get one response with
// match and error. '*' matches any run, '?' any one byte, letters ignore
// case. Patterns longer than PAT_MAX are truncated and flag error on every
// response until the next pattern. A two-entry queue sits between request
// decode and the matcher; one request is taken every clock while it has
// room, and a name end waits in it while the response is stalled. Each
// name byte updates all PAT_MAX+1 pattern positions at once. The response
// is registered, after the queue entry that held the name end.
module wildcard_name_matcher #(
   parameter int PAT_MAX = wnm_pkg::PAT_MAX_DEF
) (
   input  logic       clock,
   input  logic       reset,
   wnm_req_if.sink    req_chan,
   wnm_rsp_if.source  rsp_chan
);
   import wnm_pkg::*;

   item_type head_item;
   logic     head_valid;
   logic     head_pop;

   wnm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .head_item  (head_item),
      .head_valid (head_valid),
      .head_pop   (head_pop)
   );

   wnm_back #(
      .PAT_MAX (PAT_MAX)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_item  (head_item),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .rsp_chan   (rsp_chan)
   );

endmodule
